FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define GPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define GPM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/gpm_pkg.sv
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types and constants for the GF(2) x-power remainder block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

    localparam int POLY_BITS_DEF = 64;  // default modulus width
    localparam int CFG_W         = 64;  // modulus register width
    localparam int EXP_W         = 64;  // exponent field width
    localparam int EXP_IDX_W     = 6;   // index into the exponent
    localparam int REM_W         = 63;  // remainder field width
    localparam int TDATA_W       = 64;  // remainder padded to whole bytes

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INIT,
        ST_BIT,
        ST_SQR,
        ST_COMP,
        ST_MULX,
        ST_NEXT,
        ST_DONE
    } gpm_state_t;

    typedef struct packed {
        logic [EXP_W-1:0] exponent_n;
        logic             power_of_two_mode;
    } gpm_item_t;

    typedef struct packed {
        logic [REM_W-1:0] remainder;
        logic             zero_modulus_error;
    } gpm_result_t;

endpackage

`default_nettype wire

FILE: src/gf2_poly_power_mod_top.sv
// From input transfer to m_tvalid: P = 0 goes straight to the result, P = 1 after the degree
// scan; otherwise degree scan, init, then per exponent bit from the top, leading zeros skipped,
// a multiply by x (plain) or squaring (power-of-two) at the leading one, then per later bit a
// squaring plus multiply by x if set (plain), or composition plus squaring if set (power-of-two).
// One item at a time; the next is taken the edge after the result enters the output register.
// aresetn (sync, active low) clears the sequencer, output valid and the modulus to 0.
// ----------------------------------------------------------------------------
// gf2_poly_power_mod_top
// x^e mod P(x) over GF(2) with stream ports and a modulus write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_poly_power_mod_top #(
    parameter int POLY_BITS = gpm_pkg::POLY_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // modulus write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [gpm_pkg::CFG_W-1:0]   cfg_data,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [gpm_pkg::EXP_W-1:0]   s_tdata,   // [63:0] exponent_n
    input  wire logic [0:0]                  s_tuser,   // [0] power_of_two_mode
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [gpm_pkg::TDATA_W-1:0]      m_tdata,   // [62:0] remainder, [63] zero
    output logic [0:0]                       m_tuser    // [0] zero_modulus_error
);

    logic [gpm_pkg::CFG_W-1:0]   modulus_reg, modulus_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [gpm_pkg::TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    gpm_pkg::gpm_item_t   item;
    gpm_pkg::gpm_result_t result;
    logic                 core_idle;
    logic                 res_valid;
    logic                 res_ack;
    logic                 start;

    // no transfer is taken while reset is held
    assign cfg_ready = aresetn;
    assign s_tready  = core_idle && aresetn;
    assign start     = s_tvalid && s_tready;

    assign item.exponent_n        = s_tdata;
    assign item.power_of_two_mode = s_tuser[0];

    // output register frees when empty or being drained
    assign res_ack = !m_tvalid_reg || m_tready;

    gpm_core #(
        .POLY_BITS(POLY_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item      (item),
        .pmod_in   (modulus_reg[POLY_BITS-1:0]),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .result    (result)
    );

    always_comb begin
        modulus_next  = modulus_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (cfg_valid) begin
            modulus_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ack) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, result.remainder};
            m_tuser_next  = result.zero_modulus_error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            modulus_reg  <= modulus_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

FILE: src/gpm_mulx_unit.sv
// ----------------------------------------------------------------------------
// gpm_mulx_unit
// Shared step: multiply by x modulo P, then optionally add an operand.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_mulx_unit #(
    parameter int POLY_BITS = gpm_pkg::POLY_BITS_DEF
) (
    input  wire logic [POLY_BITS-1:0]         pmod,
    input  wire logic [$clog2(POLY_BITS)-1:0] deg,
    input  wire logic [POLY_BITS-2:0]         rmask,
    input  wire logic [POLY_BITS-2:0]         acc_in,
    input  wire logic [POLY_BITS-2:0]         addend,
    input  wire logic                         add_en,
    output logic      [POLY_BITS-2:0]         res
);

    localparam int PW = POLY_BITS - 1;

    logic [POLY_BITS-1:0] shifted;
    logic [POLY_BITS-1:0] reduced;

    always_comb begin
        shifted = {acc_in, 1'b0};
        reduced = shifted[deg] ? (shifted ^ pmod) : shifted;
        res     = (reduced[PW-1:0] & rmask) ^ (add_en ? addend : '0);
    end

endmodule

`default_nettype wire

FILE: src/gpm_core.sv
// ----------------------------------------------------------------------------
// gpm_core
// Sequencer for x^e mod P: degree scan, then square-and-multiply and modular
// composition for the power-of-two exponent, both through one shared step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_core #(
    parameter int POLY_BITS = gpm_pkg::POLY_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire gpm_pkg::gpm_item_t   item,
    input  wire logic [POLY_BITS-1:0] pmod_in,
    output logic                      idle,
    output logic                      res_valid,
    input  wire logic                 res_ack,
    output gpm_pkg::gpm_result_t      result
);

    localparam int PW    = POLY_BITS - 1;
    localparam int DEG_W = $clog2(POLY_BITS);
    localparam logic [DEG_W-1:0] TOP_IDX = DEG_W'(POLY_BITS - 1);

    gpm_pkg::gpm_state_t state_reg, state_next;

    logic [gpm_pkg::EXP_W-1:0]     n_reg, n_next;
    logic                          mode_reg, mode_next;
    logic [POLY_BITS-1:0]          pmod_reg, pmod_next;
    logic [DEG_W-1:0]              deg_reg, deg_next;
    logic [PW-1:0]                 rmask_reg, rmask_next;
    logic [gpm_pkg::EXP_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic                          started_reg, started_next;
    logic                          err_reg, err_next;
    logic [PW-1:0]                 s_reg, s_next;
    logic [PW-1:0]                 t_reg, t_next;
    logic [PW-1:0]                 acc_reg, acc_next;
    logic [DEG_W-1:0]              i_reg, i_next;
    logic [DEG_W-1:0]              j_reg, j_next;

    logic [PW-1:0] unit_acc;
    logic [PW-1:0] unit_add;
    logic          unit_add_en;
    logic [PW-1:0] unit_res;
    logic [PW-1:0] horner_val;
    logic          cur_bit;
    logic          last_bit;
    logic [DEG_W-1:0] deg_m1;

    assign cur_bit  = n_reg[bit_idx_reg];
    assign last_bit = (bit_idx_reg == '0);
    assign deg_m1   = deg_reg - 1'b1;

    // Operand steering for the shared step unit
    always_comb begin
        unit_acc    = acc_reg;
        unit_add    = s_reg;
        unit_add_en = 1'b0;
        case (state_reg)
            gpm_pkg::ST_INIT: unit_acc = PW'(1);
            gpm_pkg::ST_MULX: unit_acc = s_reg;
            gpm_pkg::ST_SQR:  unit_add_en = s_reg[i_reg];
            gpm_pkg::ST_COMP: begin
                unit_add    = t_reg;
                unit_add_en = s_reg[i_reg];
            end
            default: unit_acc = acc_reg;
        endcase
    end

    gpm_mulx_unit #(
        .POLY_BITS(POLY_BITS)
    ) u_unit (
        .pmod   (pmod_reg),
        .deg    (deg_reg),
        .rmask  (rmask_reg),
        .acc_in (unit_acc),
        .addend (unit_add),
        .add_en (unit_add_en),
        .res    (unit_res)
    );

    // Horner: t = t * s mod P + s[j]
    assign horner_val = unit_res ^ PW'(s_reg[j_reg]);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gpm_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = (pmod_in == '0) ? gpm_pkg::ST_DONE : gpm_pkg::ST_SCAN;
                end
            end
            gpm_pkg::ST_SCAN: begin
                if (pmod_reg[i_reg]) begin
                    state_next = (i_reg == '0) ? gpm_pkg::ST_DONE : gpm_pkg::ST_INIT;
                end
            end
            gpm_pkg::ST_INIT: state_next = gpm_pkg::ST_BIT;
            gpm_pkg::ST_BIT: begin
                if (!started_reg && !cur_bit) begin
                    state_next = last_bit ? gpm_pkg::ST_DONE : gpm_pkg::ST_BIT;
                end else if (!started_reg) begin
                    // first set bit: squaring/composing the start value is a no-op
                    state_next = mode_reg ? gpm_pkg::ST_SQR : gpm_pkg::ST_MULX;
                end else begin
                    state_next = mode_reg ? gpm_pkg::ST_COMP : gpm_pkg::ST_SQR;
                end
            end
            gpm_pkg::ST_SQR: begin
                if (i_reg == '0) begin
                    state_next = (!mode_reg && cur_bit) ? gpm_pkg::ST_MULX
                                                        : gpm_pkg::ST_NEXT;
                end
            end
            gpm_pkg::ST_COMP: begin
                if (i_reg == '0 && j_reg == '0) begin
                    state_next = cur_bit ? gpm_pkg::ST_SQR : gpm_pkg::ST_NEXT;
                end
            end
            gpm_pkg::ST_MULX: state_next = gpm_pkg::ST_NEXT;
            gpm_pkg::ST_NEXT: state_next = last_bit ? gpm_pkg::ST_DONE : gpm_pkg::ST_BIT;
            gpm_pkg::ST_DONE: begin
                if (res_ack) begin
                    state_next = gpm_pkg::ST_IDLE;
                end
            end
            default: state_next = gpm_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates
    always_comb begin
        n_next       = n_reg;
        mode_next    = mode_reg;
        pmod_next    = pmod_reg;
        deg_next     = deg_reg;
        rmask_next   = rmask_reg;
        bit_idx_next = bit_idx_reg;
        started_next = started_reg;
        err_next     = err_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        unique case (state_reg)
            gpm_pkg::ST_IDLE: begin
                if (start) begin
                    n_next    = item.exponent_n;
                    mode_next = item.power_of_two_mode;
                    pmod_next = pmod_in;
                    err_next  = (pmod_in == '0);
                    s_next    = '0;
                    i_next    = TOP_IDX;
                end
            end
            gpm_pkg::ST_SCAN: begin
                if (pmod_reg[i_reg]) begin
                    deg_next   = i_reg;
                    rmask_next = ~({PW{1'b1}} << i_reg);
                end else begin
                    i_next = i_reg - 1'b1;
                end
            end
            gpm_pkg::ST_INIT: begin
                s_next       = mode_reg ? unit_res : PW'(1);
                bit_idx_next = '1;
                started_next = 1'b0;
            end
            gpm_pkg::ST_BIT: begin
                acc_next = '0;
                i_next   = deg_m1;
                j_next   = deg_m1;
                t_next   = '0;
                if (!started_reg && !cur_bit) begin
                    if (!last_bit) begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                    end
                end else begin
                    started_next = 1'b1;
                end
            end
            gpm_pkg::ST_SQR: begin
                acc_next = unit_res;
                i_next   = i_reg - 1'b1;
                if (i_reg == '0) begin
                    s_next = unit_res;
                end
            end
            gpm_pkg::ST_COMP: begin
                acc_next = unit_res;
                i_next   = i_reg - 1'b1;
                if (i_reg == '0) begin
                    acc_next = '0;
                    i_next   = deg_m1;
                    if (j_reg == '0) begin
                        s_next = horner_val;
                    end else begin
                        j_next = j_reg - 1'b1;
                        t_next = horner_val;
                    end
                end
            end
            gpm_pkg::ST_MULX: s_next = unit_res;
            gpm_pkg::ST_NEXT: begin
                if (!last_bit) begin
                    bit_idx_next = bit_idx_reg - 1'b1;
                end
            end
            gpm_pkg::ST_DONE: s_next = s_reg;
            default: s_next = s_reg;
        endcase
    end

    // Outputs
    always_comb begin
        idle      = (state_reg == gpm_pkg::ST_IDLE);
        res_valid = (state_reg == gpm_pkg::ST_DONE);
        result.remainder          = gpm_pkg::REM_W'(s_reg);
        result.zero_modulus_error = err_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        mode_reg    <= mode_next;
        pmod_reg    <= pmod_next;
        deg_reg     <= deg_next;
        rmask_reg   <= rmask_next;
        bit_idx_reg <= bit_idx_next;
        started_reg <= started_next;
        err_reg     <= err_next;
        s_reg       <= s_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
    end

endmodule

`default_nettype wire

FILE: src/gpm_checker.sv
// ----------------------------------------------------------------------------
// gpm_checker
// Port-level checks for gf2_poly_power_mod_top, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpm_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [gpm_pkg::TDATA_W-1:0]       m_tdata,
    input wire logic [0:0]                        m_tuser
);

    `GPM_ASSERT_RST(a_rst_no_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // one item at a time: the block is busy right after taking an item
    `GPM_ASSERT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready after transfer")

    `GPM_ASSERT(a_err_zero_rem, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata == '0, "error result with nonzero remainder")

    `GPM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind gf2_poly_power_mod_top gpm_checker u_gpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
